[design/mpnr_pkg.sv]
// ----------------------------------------------------------------------------
// mpnr_pkg
// shared types, constants and arithmetic helpers for the minimum path block
// ----------------------------------------------------------------------------
package mpnr_pkg;

   localparam int COST_W      = 16;
   localparam int SUM_W       = 32;
   localparam int ROW_WIDTH_W = 11;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [SUM_W-1:0]       INF_SUM         = '1;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_MIN   = 11'd2;

   // word index of the row width register (paddr bit above the byte lanes)
   localparam logic CSR_ROW_WIDTH_IDX = 1'b0;

   // three path sums of one column, by direction of arrival
   typedef struct packed {
      logic [SUM_W-1:0] ul;
      logic [SUM_W-1:0] ab;
      logic [SUM_W-1:0] ur;
   } sums_type;

   localparam int SUMS_W = $bits(sums_type);

   function automatic logic [SUM_W-1:0] min2(input logic [SUM_W-1:0] a,
                                             input logic [SUM_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // saturating add, anything at or above all ones is infinity
   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  a,
                                                input logic [COST_W-1:0] c);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {{(SUM_W - COST_W + 1){1'b0}}, c};
      return (s[SUM_W] || (&s[SUM_W-1:0])) ? INF_SUM : s[SUM_W-1:0];
   endfunction

endpackage

[design/mpnr_ram.sv]
// ----------------------------------------------------------------------------
// mpnr_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module mpnr_ram #(
   parameter  int WIDTH  = 96,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/min_path_no_repeat_direction_top.sv]
// ----------------------------------------------------------------------------
// min_path_no_repeat_direction_top
// streaming minimum top-to-bottom path sum, no two equal moves in a row
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one grid cell per word in row-major order: tdata holds the
//   cell cost, tlast marks the final cell of the grid. rsp_ carries one word
//   per grid, the minimum path sum (all ones = no path).
//   csr_ holds one register, row_width, at byte 0, clamped to 2..MAX_WIDTH;
//   the user must write it only while the block is idle; it is not enforced.
// throughput and pipeline:
//   one cell per cycle while no grid result is held on rsp_. a cell is
//   accepted and its row entry is read from the row memory, sums are formed
//   and written back in stage b, and the row minimum is folded in stage c;
//   the grid result is registered from stage c and then shows on rsp_tvalid.
//   the single-port-read row memory sets the rate: each cell reads only the
//   entry to its right, the own and left entries ride along in registers.
// reset:
//   pipeline empties, row_width returns to 1024 and a new grid begins; the
//   row memory is not cleared, an entry is written before its value is used.
// stall:
//   cells keep flowing while a result waits on rsp_; req_tready drops only
//   when a second grid result reaches the last stage before the first left.
// ----------------------------------------------------------------------------
module min_path_no_repeat_direction_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,

   // input words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] cell_cost
   input  logic        req_tlast,   // last_cell

   // result words
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] best_path_sum

   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ADDR_W = $clog2(MAX_WIDTH);

   // ---------------------------------------------------------------------
   // configuration register
   // ---------------------------------------------------------------------
   logic [mpnr_pkg::ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic                             csr_hit;
   logic                             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[mpnr_pkg::CSR_ADDR_W-1] == mpnr_pkg::CSR_ROW_WIDTH_IDX);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;

   always_comb begin
      row_width_in = row_width_ff;
      if (csr_wr) begin
         row_width_in = csr_pwdata[mpnr_pkg::ROW_WIDTH_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = {{(mpnr_pkg::CSR_DATA_W - mpnr_pkg::ROW_WIDTH_W){1'b0}}, row_width_ff};
      end
   end

   // clamped width, kept as the index of the last column
   logic              width_low;
   logic              width_high;
   logic [ADDR_W-1:0] last_col;

   assign width_low  = (row_width_ff < mpnr_pkg::ROW_WIDTH_MIN);
   assign width_high = (32'(row_width_ff) > 32'(MAX_WIDTH));

   always_comb begin
      if (width_low) begin
         last_col = ADDR_W'(1);
      end else if (width_high) begin
         last_col = ADDR_W'(MAX_WIDTH - 1);
      end else begin
         last_col = ADDR_W'(row_width_ff - 11'd1);
      end
   end

   // ---------------------------------------------------------------------
   // accept stage: column tracking and lookahead read
   // ---------------------------------------------------------------------
   logic              advance;
   logic              accept;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic              first_ff, first_in;
   logic              row_end;
   logic [ADDR_W-1:0] rd_addr;

   // stage b (sum update) and stage c (row minimum) registers
   logic                          b_valid_ff, b_valid_in;
   logic [mpnr_pkg::COST_W-1:0]   b_cost_ff;
   logic                          b_last_ff;
   logic [ADDR_W-1:0]             b_col_ff;
   logic                          b_row_end_ff;
   logic                          b_first_ff;
   logic                          fwd_ff, fwd_in;

   logic                          c_valid_ff, c_valid_in;
   logic                          c_last_ff;
   logic                          c_row_end_ff;
   mpnr_pkg::sums_type            c_sums_ff;

   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [mpnr_pkg::SUM_W-1:0]    rsp_tdata_ff;
   logic [mpnr_pkg::SUM_W-1:0]    row_min_ff, row_min_in;

   // only a second grid result can hold the pipe
   assign advance    = !(c_valid_ff && c_last_ff && rsp_tvalid_ff && !rsp_tready);
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   assign row_end = (col_ff >= last_col);
   // right neighbor, or column 0 for the next row at the row end
   assign rd_addr = row_end ? '0 : col_ff + 1'b1;

   always_comb begin
      col_in   = col_ff;
      first_in = first_ff;
      if (accept) begin
         if (req_tlast) begin
            col_in   = '0;
            first_in = 1'b1;
         end else if (row_end) begin
            col_in   = '0;
            first_in = 1'b0;
         end else begin
            col_in   = col_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // row memory: three sums per column
   // ---------------------------------------------------------------------
   logic                       b_wr;
   mpnr_pkg::sums_type         new_sums;
   logic [mpnr_pkg::SUMS_W-1:0] ram_rd_data;

   assign b_wr = b_valid_ff && advance;

   mpnr_ram #(
      .WIDTH (mpnr_pkg::SUMS_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (b_wr),
      .wr_addr (b_col_ff),
      .wr_data (new_sums),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // same entry written by stage b while read: take it from stage c next cycle
   always_comb begin
      fwd_in = fwd_ff;
      if (advance) begin
         fwd_in = accept && b_valid_ff && (rd_addr == b_col_ff);
      end
   end

   always_comb begin
      b_valid_in = b_valid_ff;
      if (advance) begin
         b_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_cost_ff    <= req_tdata;
         b_last_ff    <= req_tlast;
         b_col_ff     <= col_ff;
         b_row_end_ff <= row_end;
         b_first_ff   <= first_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage b: form the three sums of this cell
   // ---------------------------------------------------------------------
   mpnr_pkg::sums_type         right_sums;  // previous row, column j+1
   mpnr_pkg::sums_type         cur_ff;      // previous row, column j
   mpnr_pkg::sums_type         left_ff;     // previous row, column j-1
   logic [mpnr_pkg::SUM_W-1:0] r_ab, r_ul, l_ur, l_ab;

   assign right_sums = fwd_ff ? c_sums_ff : mpnr_pkg::sums_type'(ram_rd_data);

   always_comb begin
      r_ab = b_row_end_ff ? mpnr_pkg::INF_SUM : right_sums.ab;
      r_ul = b_row_end_ff ? mpnr_pkg::INF_SUM : right_sums.ul;
      l_ur = (b_col_ff == '0) ? mpnr_pkg::INF_SUM : left_ff.ur;
      l_ab = (b_col_ff == '0) ? mpnr_pkg::INF_SUM : left_ff.ab;
      if (b_first_ff) begin
         new_sums.ur = {{(mpnr_pkg::SUM_W - mpnr_pkg::COST_W){1'b0}}, b_cost_ff};
         new_sums.ab = {{(mpnr_pkg::SUM_W - mpnr_pkg::COST_W){1'b0}}, b_cost_ff};
         new_sums.ul = {{(mpnr_pkg::SUM_W - mpnr_pkg::COST_W){1'b0}}, b_cost_ff};
      end else begin
         new_sums.ur = mpnr_pkg::sat_add(mpnr_pkg::min2(r_ab, r_ul), b_cost_ff);
         new_sums.ab = mpnr_pkg::sat_add(mpnr_pkg::min2(cur_ff.ur, cur_ff.ul), b_cost_ff);
         new_sums.ul = mpnr_pkg::sat_add(mpnr_pkg::min2(l_ur, l_ab), b_cost_ff);
      end
   end

   // the right entry becomes the own entry of the next cell
   always_ff @(posedge clock) begin
      if (b_wr) begin
         cur_ff       <= right_sums;
         left_ff      <= cur_ff;
         c_sums_ff    <= new_sums;
         c_last_ff    <= b_last_ff;
         c_row_end_ff <= b_row_end_ff;
      end
   end

   always_comb begin
      c_valid_in = c_valid_ff;
      if (advance) begin
         c_valid_in = b_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // stage c: row minimum and result register
   // ---------------------------------------------------------------------
   logic                       c_done;
   logic [mpnr_pkg::SUM_W-1:0] row_min_next;

   assign c_done       = c_valid_ff && advance;
   assign row_min_next = mpnr_pkg::min2(mpnr_pkg::min2(c_sums_ff.ur, c_sums_ff.ab),
                                        mpnr_pkg::min2(c_sums_ff.ul, row_min_ff));

   always_comb begin
      row_min_in    = row_min_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
      if (c_done) begin
         if (c_last_ff) begin
            row_min_in    = mpnr_pkg::INF_SUM;
            rsp_tvalid_in = 1'b1;
         end else if (c_row_end_ff) begin
            row_min_in    = mpnr_pkg::INF_SUM;
         end else begin
            row_min_in    = row_min_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (c_done && c_last_ff) begin
         rsp_tdata_ff <= row_min_next;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= mpnr_pkg::ROW_WIDTH_RESET;
         col_ff        <= '0;
         first_ff      <= 1'b1;
         b_valid_ff    <= 1'b0;
         fwd_ff        <= 1'b0;
         c_valid_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         row_min_ff    <= mpnr_pkg::INF_SUM;
      end else begin
         row_width_ff  <= row_width_in;
         col_ff        <= col_in;
         first_ff      <= first_in;
         b_valid_ff    <= b_valid_in;
         fwd_ff        <= fwd_in;
         c_valid_ff    <= c_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         row_min_ff    <= row_min_in;
      end
   end

`ifndef SYNTHESIS
   // a pending result with a second one behind it holds the input side
   a_hold_on_second_result: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && c_last_ff && rsp_tvalid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while a grid result is blocked");

   // a forwarded read always has the written sums sitting in stage c
   a_fwd_has_source: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> c_valid_ff)
      else $error("forward selected without stage c data");

   // a final cell restarts the grid at column zero on the first row
   a_grid_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (first_ff && (col_ff == '0)))
      else $error("grid did not restart after last cell");

   // a grid result clears the running minimum
   a_row_min_cleared: assert property (@(posedge clock) disable iff (reset)
      (c_done && c_last_ff) |=> (rsp_tvalid_ff && (row_min_ff == mpnr_pkg::INF_SUM)))
      else $error("row minimum not cleared after grid result");
`endif

endmodule

[tb/min_path_no_repeat_direction_top_tb.sv]
// ----------------------------------------------------------------------------
// min_path_no_repeat_direction_top_tb
// self-checking bench for the streaming minimum path sum block
// ----------------------------------------------------------------------------
// cells go in on req_ and grid results come out on rsp_. Every accepted
// cell goes through a local predictor of the path recurrence. Each rsp_ word
// is checked against the oldest queued sum. A short directed plan covers the
// reset state, cost extremes, long max-cost paths, clamped widths, a width
// cut in the middle of a row and an early grid end. After that come random
// grids under three idle patterns. Row width is changed over csr_ only once
// the block has drained.
// ----------------------------------------------------------------------------
module min_path_no_repeat_direction_top_tb;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 12;
   localparam int MAX_W         = 1024;
   // cells may still be in the pipe after the last result, leave some margin
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;
   localparam int PHASE_CELLS   = 180;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [mpnr_pkg::CSR_ADDR_W-1:0] ROW_WIDTH_ADDR =
      {mpnr_pkg::CSR_ROW_WIDTH_IDX, 2'b00};

   // directed plan: either one or more cells, or a row width write
   typedef enum bit {PLAN_CELL, PLAN_WIDTH} plan_kind_type;

   typedef struct packed {
      plan_kind_type                    kind;
      logic [mpnr_pkg::COST_W-1:0]      cost;
      bit                               last;    // tlast on the final repeat only
      int unsigned                      count;   // how many times the cell repeats
      bit                               typed;   // sum below is the known answer
      logic [mpnr_pkg::SUM_W-1:0]       want;
      logic [mpnr_pkg::ROW_WIDTH_W-1:0] width;
   } plan_row_type;

   // field order: kind, cost, last, count, typed, want, width
   localparam plan_row_type DIRECTED_PLAN [21] = '{
      // single cell grids at the reset width: the sum is the cost itself
      '{PLAN_CELL,  16'd0,     1'b1, 1,      1'b1, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd65535, 1'b1, 1,      1'b1, 32'd65535,  11'd0},
      // width zero runs as two: a small two-row grid
      '{PLAN_WIDTH, 16'd0,     1'b0, 1,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd5,     1'b0, 1,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd7,     1'b0, 1,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd3,     1'b0, 1,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd4,     1'b1, 1,      1'b0, 32'd0,      11'd0},
      // width one runs as two: three rows of max cost add up row by row
      '{PLAN_WIDTH, 16'd0,     1'b0, 1,      1'b0, 32'd0,      11'd1},
      '{PLAN_CELL,  16'd65535, 1'b0, 5,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd65535, 1'b1, 1,      1'b1, 32'd196605, 11'd0},
      // all ones width clamps to the full row, grid ends on the next row
      '{PLAN_WIDTH, 16'd0,     1'b0, 1,      1'b0, 32'd0,      11'd2047},
      '{PLAN_CELL,  16'd1,     1'b0, 1024,   1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd65535, 1'b1, 1,      1'b0, 32'd0,      11'd0},
      // width cut mid-row: column four is past the new end, next cell closes
      '{PLAN_WIDTH, 16'd0,     1'b0, 1,      1'b0, 32'd0,      11'd6},
      '{PLAN_CELL,  16'd9,     1'b0, 10,     1'b0, 32'd0,      11'd0},
      '{PLAN_WIDTH, 16'd0,     1'b0, 1,      1'b0, 32'd0,      11'd3},
      '{PLAN_CELL,  16'd2,     1'b0, 4,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd6,     1'b1, 1,      1'b0, 32'd0,      11'd0},
      // early grid end in the middle of the second row
      '{PLAN_WIDTH, 16'd0,     1'b0, 1,      1'b0, 32'd0,      11'd4},
      '{PLAN_CELL,  16'd3,     1'b0, 6,      1'b0, 32'd0,      11'd0},
      '{PLAN_CELL,  16'd0,     1'b1, 1,      1'b0, 32'd0,      11'd0}
   };

   // ------------------------------------------------------------------------
   // block ports, all inputs known from time zero
   // ------------------------------------------------------------------------
   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [15:0]                     req_tdata   = '0;   // [15:0] cell_cost
   logic                            req_tlast   = 1'b0; // last_cell
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [31:0]                     rsp_tdata;          // [31:0] best_path_sum
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [mpnr_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [mpnr_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [mpnr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   min_path_no_repeat_direction_top #(
      .MAX_WIDTH (MAX_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   // idle chance per cycle in percent, one for each side
   int unsigned send_idle = 0;
   int unsigned recv_idle = 0;

   logic [mpnr_pkg::SUM_W-1:0] expected_sums [$];   // grid sums still owed by the block
   logic [mpnr_pkg::SUM_W-1:0] got_sum;
   int unsigned                mismatches   = 0;
   int unsigned                cells_sent   = 0;
   int unsigned                sums_checked = 0;
   int unsigned                width_writes = 0;
   int unsigned                cycle_count  = 0;

   // ------------------------------------------------------------------------
   // path sum predictor: three sums per column of the previous row,
   // one for each direction the path arrived from
   // ------------------------------------------------------------------------
   logic [mpnr_pkg::SUM_W-1:0]       from_upper_right [MAX_W];
   logic [mpnr_pkg::SUM_W-1:0]       from_above       [MAX_W];
   logic [mpnr_pkg::SUM_W-1:0]       from_upper_left  [MAX_W];
   logic [mpnr_pkg::SUM_W-1:0]       left_ur, left_ab;   // previous row, column to the left
   logic [mpnr_pkg::SUM_W-1:0]       running_min;
   logic [mpnr_pkg::ROW_WIDTH_W-1:0] width_reg;
   int                               col_pos;
   bit                               first_row;

   function automatic logic [mpnr_pkg::SUM_W-1:0] lesser(
      input logic [mpnr_pkg::SUM_W-1:0] a,
      input logic [mpnr_pkg::SUM_W-1:0] b);
      return (b < a) ? b : a;
   endfunction

   // path sum plus cell cost, pinned at all ones
   function automatic logic [mpnr_pkg::SUM_W-1:0] add_cost(
      input logic [mpnr_pkg::SUM_W-1:0]  a,
      input logic [mpnr_pkg::COST_W-1:0] c);
      logic [mpnr_pkg::SUM_W:0] s;
      s = {1'b0, a} + (mpnr_pkg::SUM_W + 1)'(c);
      return (s >= {1'b0, mpnr_pkg::INF_SUM}) ? mpnr_pkg::INF_SUM
                                              : s[mpnr_pkg::SUM_W-1:0];
   endfunction

   // width register as the block uses it
   function automatic int effective_width();
      int w;
      w = int'(width_reg);
      if (w < int'(mpnr_pkg::ROW_WIDTH_MIN)) w = int'(mpnr_pkg::ROW_WIDTH_MIN);
      if (w > MAX_W) w = MAX_W;
      return w;
   endfunction

   function automatic void start_grid();
      col_pos     = 0;
      first_row   = 1'b1;
      running_min = mpnr_pkg::INF_SUM;
      left_ur     = mpnr_pkg::INF_SUM;
      left_ab     = mpnr_pkg::INF_SUM;
   endfunction

   // fold one accepted cell in; returns 1 with the grid minimum on tlast
   function automatic bit fold_cell(input logic [mpnr_pkg::COST_W-1:0] cost,
                                    input bit last,
                                    output logic [mpnr_pkg::SUM_W-1:0] grid_min);
      int                         w, j;
      logic [mpnr_pkg::SUM_W-1:0] n_ur, n_ab, n_ul, r_ab, r_ul, l_ur, l_ab, m;
      w = effective_width();
      j = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
      if (first_row) begin
         n_ur = mpnr_pkg::SUM_W'(cost);
         n_ab = mpnr_pkg::SUM_W'(cost);
         n_ul = mpnr_pkg::SUM_W'(cost);
      end else begin
         r_ab = mpnr_pkg::INF_SUM;
         r_ul = mpnr_pkg::INF_SUM;
         l_ur = mpnr_pkg::INF_SUM;
         l_ab = mpnr_pkg::INF_SUM;
         if (j + 1 < w) begin
            r_ab = from_above[j + 1];
            r_ul = from_upper_left[j + 1];
         end
         if (j > 0) begin
            l_ur = left_ur;
            l_ab = left_ab;
         end
         // no repeat: a down-right arrival cannot come from a down-right one, etc
         n_ur = add_cost(lesser(r_ab, r_ul), cost);
         n_ab = add_cost(lesser(from_upper_right[j], from_upper_left[j]), cost);
         n_ul = add_cost(lesser(l_ur, l_ab), cost);
      end
      left_ur = from_upper_right[j];
      left_ab = from_above[j];
      from_upper_right[j] = n_ur;
      from_above[j]       = n_ab;
      from_upper_left[j]  = n_ul;
      m = lesser(running_min, lesser(n_ur, lesser(n_ab, n_ul)));
      grid_min = m;
      if (last) begin
         start_grid();
         return 1'b1;
      end
      if (j + 1 >= w) begin
         col_pos     = 0;
         first_row   = 1'b0;
         running_min = mpnr_pkg::INF_SUM;
      end else begin
         col_pos     = j + 1;
         running_min = m;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------------
   // reporting
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("[%0d] mismatch: %s", cycle_count, msg);
      mismatches++;
   endtask

   // ------------------------------------------------------------------------
   // drivers, all called right after a rising edge
   // ------------------------------------------------------------------------
   // one cell word; typed rows queue the known sum instead of the predicted one
   task automatic send_cell(input logic [mpnr_pkg::COST_W-1:0] cost, input bit last,
                            input bit typed, input logic [mpnr_pkg::SUM_W-1:0] want);
      logic [mpnr_pkg::SUM_W-1:0] sum;
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cost;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      // word taken at this edge; valid stays high unless the next call drops it
      cells_sent++;
      if (fold_cell(cost, last, sum))
         expected_sums.push_back(typed ? want : sum);
   endtask

   // row width write plus read back, only once the block has gone quiet
   task automatic write_row_width(input logic [mpnr_pkg::ROW_WIDTH_W-1:0] value);
      req_tvalid <= 1'b0;
      // sender holds off until every owed result is out
      while (expected_sums.size() != 0) @(posedge clock);
      // cells with no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ROW_WIDTH_ADDR;
      csr_pwdata  <= mpnr_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      width_reg = value;
      width_writes++;
      // read back as a second transfer
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== mpnr_pkg::CSR_DATA_W'(value))
         report_mismatch($sformatf("row_width reads %h after writing %h",
                                   csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // random stimulus
   // ------------------------------------------------------------------------
   // mostly narrow rows, a few clamped and full-width ones
   function automatic logic [mpnr_pkg::ROW_WIDTH_W-1:0] pick_row_width();
      int unsigned d;
      d = $urandom_range(0, 99);
      if (d < 5)       return mpnr_pkg::ROW_WIDTH_W'($urandom_range(0, 1));
      else if (d < 7)  return mpnr_pkg::ROW_WIDTH_W'($urandom_range(1025, 2047));
      else if (d < 8)  return mpnr_pkg::ROW_WIDTH_W'(MAX_W);
      else if (d < 58) return mpnr_pkg::ROW_WIDTH_W'($urandom_range(2, 4));
      else if (d < 88) return mpnr_pkg::ROW_WIDTH_W'($urandom_range(5, 12));
      else             return mpnr_pkg::ROW_WIDTH_W'($urandom_range(13, 64));
   endfunction

   // zero and full scale often, small costs so sums tie, else anything
   function automatic logic [mpnr_pkg::COST_W-1:0] pick_cost();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return mpnr_pkg::COST_W'($urandom_range(0, 15));
         default: return mpnr_pkg::COST_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // whole grids with random content; some end early, some get a narrower
   // width part way through, the last cell always carries tlast
   task automatic run_random_phase();
      int unsigned                      sent_here;
      int                               eff, rows, total, cut_at;
      logic [mpnr_pkg::ROW_WIDTH_W-1:0] cut_width;
      sent_here = 0;
      while (sent_here < PHASE_CELLS) begin
         if ($urandom_range(0, 2) != 0)
            write_row_width(pick_row_width());
         eff   = effective_width();
         rows  = (eff >= 256) ? 1 : $urandom_range(1, 8);
         total = rows * eff;
         if ($urandom_range(0, 9) == 0)
            total = $urandom_range(1, total);
         // a grid never runs past the cells left for this phase
         if (total > int'(PHASE_CELLS - sent_here))
            total = int'(PHASE_CELLS - sent_here);
         cut_at    = -1;
         cut_width = '0;
         // only narrowing mid-grid, so every column read was written this grid
         if (eff > 2 && total > 1 && $urandom_range(0, 11) == 0) begin
            cut_at    = $urandom_range(1, total - 1);
            cut_width = mpnr_pkg::ROW_WIDTH_W'($urandom_range(2, eff - 1));
         end
         for (int k = 0; k < total; k++) begin
            if (k == cut_at)
               write_row_width(cut_width);
            send_cell(pick_cost(), k == total - 1, 1'b0, '0);
         end
         sent_here += total;
      end
   endtask

   // ------------------------------------------------------------------------
   // result side: random back-pressure and the compare against queued sums
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sums_checked++;
         if (expected_sums.size() == 0) begin
            report_mismatch($sformatf("unexpected result word %h", rsp_tdata));
         end else begin
            got_sum = expected_sums.pop_front();
            if (rsp_tdata !== got_sum)
               report_mismatch($sformatf("best_path_sum %h, predicted %h",
                                         rsp_tdata, got_sum));
         end
      end
   end

   // hard stop on a hang
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed",
                  cycle_count, expected_sums.size());
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      // predictor stores start at zero; the block's row memory is not cleared
      for (int i = 0; i < MAX_W; i++) begin
         from_upper_right[i] = '0;
         from_above[i]       = '0;
         from_upper_left[i]  = '0;
      end
      width_reg = mpnr_pkg::ROW_WIDTH_RESET;
      start_grid();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed plan, sender idles lightly and receiver heavily
      send_idle = 30;
      recv_idle = 72;
      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].kind == PLAN_WIDTH) begin
            write_row_width(DIRECTED_PLAN[i].width);
         end else begin
            for (int k = 0; k < int'(DIRECTED_PLAN[i].count); k++)
               send_cell(DIRECTED_PLAN[i].cost,
                         DIRECTED_PLAN[i].last && (k == int'(DIRECTED_PLAN[i].count) - 1),
                         DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
         end
      end

      // random grids under each idle pattern in turn
      run_random_phase();
      send_idle = 72;
      recv_idle = 30;
      run_random_phase();
      send_idle = 0;
      recv_idle = 0;
      run_random_phase();

      // wind down: all sums in, then a few quiet cycles for strays
      req_tvalid <= 1'b0;
      while (expected_sums.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d cells, %0d grid sums compared, %0d row width writes",
               cells_sent, sums_checked, width_writes);
      $display("incl. max-cost rows, clamped widths, mid-row cuts, early ends");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
